@@ hw/rtl/scan_polar_to_layered_points_assert.svh @@
// assertion macros for the scan polar-to-points block
// depends on nothing; expects the including module to have clock and reset
`ifndef SCAN_POLAR_TO_LAYERED_POINTS_ASSERT_SVH
`define SCAN_POLAR_TO_LAYERED_POINTS_ASSERT_SVH

// condition implies consequence in the same cycle
`define S2LP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the following cycle
`define S2LP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/s2lp_pkg.sv @@
// shared widths, constants, types and the arctangent table
// depends on nothing; used by every other file of the block but the assertion macro header
`default_nettype none

package s2lp_pkg;

   // field widths
   localparam int RangeW   = 16;
   localparam int AngleW   = 16;
   localparam int IntenW   = 16;
   localparam int SpacingW = 9;
   localparam int XyW      = 17;
   localparam int ZW       = 12;

   // configuration port
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;
   localparam logic [CsrIdxW-1:0] CSR_ANGLE_START   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_ANGLE_STEP    = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_LAYER_SPACING = 2'd2;

   // register reset values
   localparam logic [AngleW-1:0]   AngleStartReset = 16'd0;
   localparam logic [AngleW-1:0]   AngleStepReset  = 16'd182;
   localparam logic [SpacingW-1:0] SpacingReset    = 9'd200;

   // cordic datapath
   localparam int CordicSteps = 16;
   localparam int IterW       = 4;
   localparam int AccW        = 35;
   localparam int PhaseW      = 31;
   localparam logic [RangeW-1:0] CordicGain = 16'd39797;
   localparam logic [ZW-1:0]     ZMax       = 12'd4095;

   // commands from the controller to the datapath
   typedef struct packed {
      logic             load;
      logic             rotate;
      logic [IterW-1:0] iter;
      logic             round;
      logic             height_add;
   } s2lp_cmd_type;

   // result payload held by the datapath
   typedef struct packed {
      logic signed [XyW-1:0] x_mm;
      logic signed [XyW-1:0] y_mm;
      logic [ZW-1:0]         z_mm;
      logic [IntenW-1:0]     intensity;
   } s2lp_point_type;

   // arctangent of 2^-i in units of 2^-30 turn
   function automatic logic signed [PhaseW-1:0] atan_entry(input logic [IterW-1:0] idx);
      logic signed [PhaseW-1:0] v;
      unique case (idx)
         4'd0:  v = 31'sd134217728;
         4'd1:  v = 31'sd79233351;
         4'd2:  v = 31'sd41864727;
         4'd3:  v = 31'sd21251189;
         4'd4:  v = 31'sd10666833;
         4'd5:  v = 31'sd5338616;
         4'd6:  v = 31'sd2669960;
         4'd7:  v = 31'sd1335061;
         4'd8:  v = 31'sd667541;
         4'd9:  v = 31'sd333772;
         4'd10: v = 31'sd166886;
         4'd11: v = 31'sd83443;
         4'd12: v = 31'sd41722;
         4'd13: v = 31'sd20861;
         4'd14: v = 31'sd10430;
         4'd15: v = 31'sd5215;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/s2lp_req_if.sv @@
// sample channel: valid/ready handshake with the range sample payload
// depends on s2lp_pkg
`default_nettype none

interface s2lp_req_if import s2lp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RangeW-1:0] range_mm;
   logic              range_valid;
   logic [IntenW-1:0] intensity;
   logic              scan_start;

   modport source (output valid, output range_mm, output range_valid,
                   output intensity, output scan_start, input ready);
   modport sink   (input valid, input range_mm, input range_valid,
                   input intensity, input scan_start, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/s2lp_rsp_if.sv @@
// point channel: valid/ready handshake with one layered point
// depends on s2lp_pkg
`default_nettype none

interface s2lp_rsp_if import s2lp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic signed [XyW-1:0] x_mm;
   logic signed [XyW-1:0] y_mm;
   logic [ZW-1:0]         z_mm;
   logic [IntenW-1:0]     point_intensity;
   logic                  last_of_run;

   modport source (output valid, output x_mm, output y_mm, output z_mm,
                   output point_intensity, output last_of_run, input ready);
   modport sink   (input valid, input x_mm, input y_mm, input z_mm,
                   input point_intensity, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/s2lp_dpath.sv @@
// datapath: config registers, beam angle, iterative cordic, result registers
// depends on s2lp_pkg; driven by s2lp_ctrl commands
`default_nettype none

module s2lp_dpath import s2lp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic [RangeW-1:0]   range_mm,
   input  logic [IntenW-1:0]   intensity,
   input  logic                scan_start,
   input  s2lp_cmd_type        cmd,
   output s2lp_point_type      point
);

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;
   localparam logic signed [AccW-1:0] AccMax  = 35'sd65535;
   localparam logic signed [AccW-1:0] AccMin  = -35'sd65535;
   localparam logic signed [AccW-1:0] RoundUp = 35'sd32768;
   localparam logic [AngleW-1:0]      EighthTurn = 16'h2000;

   logic [AngleW-1:0]   angle_start_ff, angle_start_in;
   logic [AngleW-1:0]   angle_step_ff, angle_step_in;
   logic [SpacingW-1:0] spacing_ff, spacing_in;
   logic [AngleW-1:0]   next_angle_ff, next_angle_in;

   logic signed [AccW-1:0]   cx_ff, cx_in;
   logic signed [AccW-1:0]   cy_ff, cy_in;
   logic signed [PhaseW-1:0] cz_ff, cz_in;
   logic [1:0]               quad_ff, quad_in;
   logic [IntenW-1:0]        inten_ff, inten_in;
   logic signed [XyW-1:0]    x_out_ff, x_out_in;
   logic signed [XyW-1:0]    y_out_ff, y_out_in;
   logic [ZW-1:0]            height_ff, height_in;

   logic [AngleW-1:0]        cur_angle;
   logic [AngleW-1:0]        shifted;
   logic signed [14:0]       phi;
   logic [2*RangeW-1:0]      product;
   logic signed [AccW-1:0]   dx, dy;
   logic signed [PhaseW-1:0] atan_val;
   logic signed [AccW-1:0]   rnd_x, rnd_y;
   logic signed [XyW-1:0]    cos_v, sin_v;
   logic [ZW:0]              height_sum;

   function automatic logic signed [XyW-1:0] clamp_xy(input logic signed [AccW-1:0] v);
      logic signed [AccW-1:0] t;
      t = v;
      if (v > AccMax) begin
         t = AccMax;
      end else if (v < AccMin) begin
         t = AccMin;
      end
      return t[XyW-1:0];
   endfunction

   // configuration writes, unknown index ignored
   always_comb begin
      angle_start_in = angle_start_ff;
      angle_step_in  = angle_step_ff;
      spacing_in     = spacing_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ANGLE_START:   angle_start_in = csr_wdata[AngleW-1:0];
            CSR_ANGLE_STEP:    angle_step_in  = csr_wdata[AngleW-1:0];
            CSR_LAYER_SPACING: spacing_in     = csr_wdata[SpacingW-1:0];
            default: ;
         endcase
      end
   end

   // beam angle, advances on every accepted sample
   assign cur_angle     = scan_start ? angle_start_ff : next_angle_ff;
   assign next_angle_in = cmd.load ? cur_angle + angle_step_ff : next_angle_ff;

   // quadrant split and scaled start vector
   assign shifted = cur_angle + EighthTurn;
   assign phi     = $signed({1'b0, shifted[13:0]}) - 15'sd8192;
   assign product = range_mm * CordicGain;

   // one cordic micro-rotation per cycle
   assign dx       = cy_ff >>> cmd.iter;
   assign dy       = cx_ff >>> cmd.iter;
   assign atan_val = atan_entry(cmd.iter);

   always_comb begin
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      quad_in  = quad_ff;
      inten_in = inten_ff;
      if (cmd.load) begin
         cx_in    = $signed({{(AccW-2*RangeW){1'b0}}, product});
         cy_in    = '0;
         cz_in    = $signed({{2{phi[14]}}, phi, 14'b0});
         quad_in  = shifted[15:14];
         inten_in = intensity;
      end else if (cmd.rotate) begin
         if (!cz_ff[PhaseW-1]) begin
            cx_in = cx_ff - dx;
            cy_in = cy_ff + dy;
            cz_in = cz_ff - atan_val;
         end else begin
            cx_in = cx_ff + dx;
            cy_in = cy_ff - dy;
            cz_in = cz_ff + atan_val;
         end
      end
   end

   // rounding, saturation and quadrant rotation
   assign rnd_x = (cx_ff + RoundUp) >>> 16;
   assign rnd_y = (cy_ff + RoundUp) >>> 16;
   assign cos_v = clamp_xy(rnd_x);
   assign sin_v = clamp_xy(rnd_y);

   always_comb begin
      x_out_in = x_out_ff;
      y_out_in = y_out_ff;
      if (cmd.round) begin
         unique case (quad_ff)
            QUAD_0: begin
               x_out_in = cos_v;
               y_out_in = sin_v;
            end
            QUAD_1: begin
               x_out_in = -sin_v;
               y_out_in = cos_v;
            end
            QUAD_2: begin
               x_out_in = -cos_v;
               y_out_in = -sin_v;
            end
            QUAD_3: begin
               x_out_in = sin_v;
               y_out_in = -cos_v;
            end
         endcase
      end
   end

   // copy height, saturating running sum of the spacing
   assign height_sum = {1'b0, height_ff} + {{(ZW+1-SpacingW){1'b0}}, spacing_ff};

   always_comb begin
      height_in = height_ff;
      if (cmd.round) begin
         height_in = '0;
      end else if (cmd.height_add) begin
         height_in = (height_sum > {1'b0, ZMax}) ? ZMax : height_sum[ZW-1:0];
      end
   end

   // control and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_start_ff <= AngleStartReset;
         angle_step_ff  <= AngleStepReset;
         spacing_ff     <= SpacingReset;
         next_angle_ff  <= '0;
      end else begin
         angle_start_ff <= angle_start_in;
         angle_step_ff  <= angle_step_in;
         spacing_ff     <= spacing_in;
         next_angle_ff  <= next_angle_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      quad_ff   <= quad_in;
      inten_ff  <= inten_in;
      x_out_ff  <= x_out_in;
      y_out_ff  <= y_out_in;
      height_ff <= height_in;
   end

   assign point.x_mm      = x_out_ff;
   assign point.y_mm      = y_out_ff;
   assign point.z_mm      = height_ff;
   assign point.intensity = inten_ff;

endmodule

`default_nettype wire

@@ hw/rtl/s2lp_ctrl.sv @@
// controller: sequences load, cordic iterations, rounding and copy output
// depends on s2lp_pkg and the assertion macro header
`default_nettype none

`include "scan_polar_to_layered_points_assert.svh"

module s2lp_ctrl import s2lp_pkg::*; #(
   parameter int LAYERS = 11
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_range_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_last,
   output s2lp_cmd_type cmd
);

   localparam int CopyW = $clog2(LAYERS + 1);
   localparam logic [CopyW-1:0] LastCopy = CopyW'(LAYERS);
   localparam logic [IterW-1:0] LastIter = IterW'(CordicSteps - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROT   = 2'd1;
   localparam logic [1:0] ST_ROUND = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IterW-1:0] iter_ff, iter_in;
   logic [CopyW-1:0] copy_ff, copy_in;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      iter_in        = iter_ff;
      copy_in        = copy_ff;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      rsp_last       = (copy_ff == LastCopy);
      cmd.load       = 1'b0;
      cmd.rotate     = 1'b0;
      cmd.iter       = iter_ff;
      cmd.round      = 1'b0;
      cmd.height_add = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               iter_in  = '0;
               if (req_range_valid) begin
                  state_in = ST_ROT;
               end
            end
         end
         ST_ROT: begin
            cmd.rotate = 1'b1;
            if (iter_ff == LastIter) begin
               state_in = ST_ROUND;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            copy_in   = '0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.height_add = (copy_ff != '0);
               if (copy_ff == LastCopy) begin
                  state_in = ST_IDLE;
               end else begin
                  copy_in = copy_ff + 1'b1;
               end
            end
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
         copy_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         copy_ff  <= copy_in;
      end
   end

   // checks
   `S2LP_ASSERT_NOW(a_ready_excl, req_ready, !rsp_valid, "sample taken while point pending")
   `S2LP_ASSERT_NEXT(a_valid_rot, req_valid && req_ready && req_range_valid, state_ff == ST_ROT && iter_ff == '0, "valid sample did not start cordic")
   `S2LP_ASSERT_NEXT(a_drop_idle, req_valid && req_ready && !req_range_valid, req_ready, "dropped sample left idle")
   `S2LP_ASSERT_NEXT(a_round_emit, state_ff == ST_ROUND, rsp_valid && copy_ff == '0, "rounding not followed by first copy")
   `S2LP_ASSERT_NEXT(a_last_idle, rsp_valid && rsp_ready && rsp_last, req_ready, "last copy did not return to idle")

endmodule

`default_nettype wire

@@ hw/rtl/scan_polar_to_layered_points.sv @@
// top level: range samples in, layered cartesian points out
// depends on s2lp_pkg, s2lp_req_if, s2lp_rsp_if, s2lp_ctrl, s2lp_dpath
//
//   channel   direction  handshake           contents
//   req_ch    in         valid/ready         range_mm, range_valid, intensity, scan_start
//   rsp_ch    out        valid/ready         x_mm, y_mm, z_mm, point_intensity, last_of_run
//   csr_*     in         csr_we, no wait     csr_index, csr_wdata
//
// a valid sample is loaded, rotated by 16 cordic iterations through one shared
// shift-add unit, rounded and then emitted as LAYERS+1 copies; a dropped
// sample is only loaded, which advances the beam angle.
// reset restores the register defaults and a zero beam angle; no clearing pass.
// a low rsp_ch.ready holds the current copy; no sample is taken until the last copy leaves.
`default_nettype none

module scan_polar_to_layered_points import s2lp_pkg::*; #(
   parameter int LAYERS = 11
) (
   input  logic                clock,
   input  logic                reset,
   s2lp_req_if.sink            req_ch,
   s2lp_rsp_if.source          rsp_ch,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   s2lp_cmd_type   cmd;
   s2lp_point_type point;
   logic           rsp_last;

   // sequencer
   s2lp_ctrl #(
      .LAYERS (LAYERS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_range_valid (req_ch.range_valid),
      .req_ready       (req_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_last        (rsp_last),
      .cmd             (cmd)
   );

   // arithmetic and registers
   s2lp_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .range_mm   (req_ch.range_mm),
      .intensity  (req_ch.intensity),
      .scan_start (req_ch.scan_start),
      .cmd        (cmd),
      .point      (point)
   );

   // result payload
   assign rsp_ch.x_mm            = point.x_mm;
   assign rsp_ch.y_mm            = point.y_mm;
   assign rsp_ch.z_mm            = point.z_mm;
   assign rsp_ch.point_intensity = point.intensity;
   assign rsp_ch.last_of_run     = rsp_last;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for scan_polar_to_layered_points: directed and random range samples
// depends on s2lp_pkg, s2lp_req_if, s2lp_rsp_if and the block itself
`timescale 1ns / 100ps

module tb_top;
   import s2lp_pkg::*;

   localparam int Layers         = 11;
   localparam int MaxIdle        = 13;
   localparam int HoldOffCycles  = 300;
   localparam int SettleCycles   = 40;
   localparam int WatchdogLimit  = 2000;
   localparam int ReportLimit    = 10;
   localparam int RandomPhases   = 5;
   localparam int PhaseItems     = 76;
   localparam logic [CsrIdxW-1:0] CSR_UNUSED = 2'd3;

   // arctangent of 2^-i, units of 2^-30 turn
   localparam longint AtanTurns [16] = '{
      134217728, 79233351, 41864727, 21251189, 10666833, 5338616,
      2669960, 1335061, 667541, 333772, 166886, 83443,
      41722, 20861, 10430, 5215
   };

   typedef struct packed {
      logic signed [XyW-1:0] x_mm;
      logic signed [XyW-1:0] y_mm;
      logic [ZW-1:0]         z_mm;
      logic [IntenW-1:0]     inten;
      logic                  last;
   } layered_point_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   s2lp_req_if req_ch ();
   s2lp_rsp_if rsp_ch ();

   scan_polar_to_layered_points #(.LAYERS(Layers)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block's registers and beam angle
   logic [AngleW-1:0]   beam_angle;
   logic [AngleW-1:0]   cfg_angle_start;
   logic [AngleW-1:0]   cfg_angle_step;
   logic [SpacingW-1:0] cfg_spacing;

   layered_point_type pending_points [$];
   int                fail_count;
   bit                steady_flow;
   bit                hold_off_request;
   int                stalled_cycles;

   // clock, period 20 ns
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint clamp_coord(input longint v);
      if (v > 65535) return 65535;
      if (v < -65535) return -65535;
      return v;
   endfunction

   // fixed-point cordic rotation of (r, 0) by the beam angle
   function automatic void beam_to_xy(input logic [RangeW-1:0] r, input logic [AngleW-1:0] ang,
                                      output logic signed [XyW-1:0] px,
                                      output logic signed [XyW-1:0] py);
      logic [AngleW-1:0] shifted;
      longint phi, x, y, z, dx, dy, c, s;
      shifted = ang + 16'h2000;
      phi = longint'(shifted[13:0]) - 64'sd8192;
      x = longint'(r) * longint'(CordicGain);
      y = 0;
      z = phi * 16384;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - AtanTurns[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + AtanTurns[i];
         end
      end
      c = clamp_coord((x + 32768) >>> 16);
      s = clamp_coord((y + 32768) >>> 16);
      // quadrant rotation
      case (shifted[15:14])
         2'd0: begin px = XyW'(c);  py = XyW'(s);  end
         2'd1: begin px = XyW'(-s); py = XyW'(c);  end
         2'd2: begin px = XyW'(-c); py = XyW'(-s); end
         default: begin px = XyW'(s); py = XyW'(-c); end
      endcase
   endfunction

   // advance the beam angle and queue the layered copies of a valid sample
   function automatic void convert_sample(input logic [RangeW-1:0] range_mm,
                                          input logic range_valid,
                                          input logic [IntenW-1:0] intensity,
                                          input logic scan_start);
      logic [AngleW-1:0]     ang;
      logic signed [XyW-1:0] px, py;
      int                    h;
      layered_point_type     p;
      ang = scan_start ? cfg_angle_start : beam_angle;
      beam_angle = ang + cfg_angle_step;
      if (!range_valid) return;
      beam_to_xy(range_mm, ang, px, py);
      for (int k = 0; k <= Layers; k++) begin
         h = (k == 0) ? 0 : (k - 1) * int'(cfg_spacing);
         if (h > int'(ZMax)) h = int'(ZMax);
         p.x_mm  = px;
         p.y_mm  = py;
         p.z_mm  = h[ZW-1:0];
         p.inten = intensity;
         p.last  = (k == Layers);
         pending_points.push_back(p);
      end
   endfunction

   // one register write, mirrored in the shadow copy
   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ANGLE_START:   cfg_angle_start = data;
         CSR_ANGLE_STEP:    cfg_angle_step  = data;
         CSR_LAYER_SPACING: cfg_spacing     = data[SpacingW-1:0];
         default: ;
      endcase
   endtask

   // offer one sample after a random gap (none in steady flow) and wait for its transaction
   task automatic send_sample(input logic [RangeW-1:0] range_mm, input logic range_valid,
                              input logic [IntenW-1:0] intensity, input logic scan_start);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, MaxIdle);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.range_mm    <= range_mm;
      req_ch.range_valid <= range_valid;
      req_ch.intensity   <= intensity;
      req_ch.scan_start  <= scan_start;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      convert_sample(range_mm, range_valid, intensity, scan_start);
   endtask

   // mostly valid samples, ranges biased toward small and near-full values
   task automatic send_random_sample();
      logic [RangeW-1:0] r;
      case ($urandom_range(0, 3))
         0: r = RangeW'($urandom_range(0, 255));
         1: r = RangeW'($urandom_range(65000, 65535));
         default: r = RangeW'($urandom);
      endcase
      send_sample(r, $urandom_range(0, 9) != 0, IntenW'($urandom),
                  $urandom_range(0, 15) == 0);
   endtask

   // stop offering, wait for every point, then let the block settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // register defaults straight out of reset, beam angle starting at zero
   task automatic test_reset_defaults();
      send_sample(16'd1000, 1'b1, 16'h0000, 1'b0);
      send_sample(16'd1000, 1'b1, 16'h5A5A, 1'b0);
      send_sample(16'd77, 1'b0, 16'h1234, 1'b0);
   endtask

   // full range around every octant, zero range, dropped samples, unused index
   task automatic test_octants_and_extremes();
      drain();
      csr_write(CSR_ANGLE_START, 16'hE000);
      csr_write(CSR_ANGLE_STEP, 16'h2000);
      csr_write(CSR_LAYER_SPACING, 16'hFFFF);
      csr_write(CSR_UNUSED, 16'h0001);
      send_sample(16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
      for (int i = 0; i < 7; i++)
         send_sample(16'hFFFF, 1'b1, (i % 2) ? 16'hFFFF : 16'h0000, 1'b0);
      send_sample(16'h0000, 1'b1, 16'hAAAA, 1'b0);
      send_sample(16'hFFFF, 1'b0, 16'hFFFF, 1'b0);
      send_sample(16'h8001, 1'b0, 16'h0000, 1'b1);
      send_sample(16'h7FFE, 1'b1, 16'h5555, 1'b0);
      // steps of one across the octant boundary, flat layers
      drain();
      csr_write(CSR_ANGLE_START, 16'h1FFE);
      csr_write(CSR_ANGLE_STEP, 16'h0001);
      csr_write(CSR_LAYER_SPACING, 16'h0000);
      for (int i = 0; i < 4; i++)
         send_sample(16'hC350, 1'b1, 16'h00FF, i == 0);
   endtask

   // receiver holds off while samples keep coming, so the input stalls
   task automatic test_output_backpressure();
      drain();
      csr_write(CSR_LAYER_SPACING, 16'd400);
      hold_off_request = 1'b1;
      repeat (8) send_random_sample();
   endtask

   // random samples under several register settings
   task automatic test_random_scans();
      for (int phase = 0; phase < RandomPhases; phase++) begin
         drain();
         steady_flow = (phase == 0);
         case (phase)
            0: begin
               csr_write(CSR_ANGLE_START, 16'h0000);
               csr_write(CSR_ANGLE_STEP, 16'h0000);
               csr_write(CSR_LAYER_SPACING, 16'h0000);
            end
            1: begin
               csr_write(CSR_ANGLE_START, 16'hFFFF);
               csr_write(CSR_ANGLE_STEP, 16'hFFFF);
               csr_write(CSR_LAYER_SPACING, 16'hFE00 | 16'd511);
            end
            2: begin
               csr_write(CSR_ANGLE_START, CsrDataW'($urandom));
               csr_write(CSR_ANGLE_STEP, CsrDataW'($urandom));
               csr_write(CSR_LAYER_SPACING, 16'd400);
            end
            default: begin
               csr_write(CSR_ANGLE_START, CsrDataW'($urandom));
               csr_write(CSR_ANGLE_STEP, CsrDataW'($urandom_range(1, 400)));
               csr_write(CSR_LAYER_SPACING, CsrDataW'($urandom));
            end
         endcase
         for (int i = 0; i < PhaseItems; i++) send_random_sample();
      end
      steady_flow = 1'b0;
   endtask

   // stimulus
   initial begin
      req_ch.valid       <= 1'b0;
      req_ch.range_mm    <= '0;
      req_ch.range_valid <= 1'b0;
      req_ch.intensity   <= '0;
      req_ch.scan_start  <= 1'b0;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      reset              <= 1'b1;
      beam_angle         = '0;
      cfg_angle_start    = AngleStartReset;
      cfg_angle_step     = AngleStepReset;
      cfg_spacing        = SpacingReset;
      fail_count         = 0;
      steady_flow        = 1'b0;
      hold_off_request   = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_octants_and_extremes();
      test_output_backpressure();
      test_random_scans();
      drain();

      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // receiver: random stalls, one long hold-off on request, checks each point
   initial begin : point_checker
      layered_point_type got, want;
      int                stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_off_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
            hold_off_request = 1'b0;
         end
         stall = steady_flow ? 0 : $urandom_range(0, MaxIdle);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got.x_mm  = rsp_ch.x_mm;
         got.y_mm  = rsp_ch.y_mm;
         got.z_mm  = rsp_ch.z_mm;
         got.inten = rsp_ch.point_intensity;
         got.last  = rsp_ch.last_of_run;
         if (pending_points.size() == 0) begin
            fail_count++;
            if (fail_count <= ReportLimit)
               $display("unexpected point: x=%0d y=%0d z=%0d i=%0d last=%0b",
                        got.x_mm, got.y_mm, got.z_mm, got.inten, got.last);
         end else begin
            want = pending_points.pop_front();
            if (got.x_mm !== want.x_mm || got.y_mm !== want.y_mm ||
                got.z_mm !== want.z_mm || got.inten !== want.inten ||
                got.last !== want.last) begin
               fail_count++;
               if (fail_count <= ReportLimit)
                  $display("point mismatch: expected x=%0d y=%0d z=%0d i=%0d last=%0b, %s",
                           want.x_mm, want.y_mm, want.z_mm, want.inten, want.last,
                           $sformatf("got x=%0d y=%0d z=%0d i=%0d last=%0b",
                                     got.x_mm, got.y_mm, got.z_mm, got.inten, got.last));
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WatchdogLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
